// File: sv/cdt_pkg.sv
package cdt_pkg;

	// lane count and default sizes
	localparam int LANES             = 3;
	localparam int LANE_W            = 2;
	localparam int QUEUE_DEPTH_DEF   = 8;
	localparam int COUNT_BITS_DEF    = 8;

	// transaction codes
	localparam logic KIND_BOX  = 1'b0;
	localparam logic KIND_TICK = 1'b1;
	localparam logic [LANE_W-1:0] BOX_EMPTY = 2'd3;
	localparam logic [LANE_W-1:0] LANE_NONE = 2'd3;

	// controller states
	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic box;        // apply a box event
		logic tick_rd;    // read the head entry of the ticked lane
		logic tick_eval;  // pop or decrement the head entry read before
		logic load_res;   // load the result register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic tick_hit;   // ticked lane exists and its queue is not empty
	} sts_t;

endpackage

// File: sv/cdt_if.sv
interface cdt_evt_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [cdt_pkg::LANE_W-1:0]     box_type;
	logic [cdt_pkg::LANE_W-1:0]     tick_lane;

	modport source (output valid, kind, box_type, tick_lane, input ready);
	modport sink (input valid, kind, box_type, tick_lane, output ready);
endinterface

interface cdt_res_if;
	logic valid;
	logic ready;
	logic fire;

	modport source (output valid, fire, input ready);
	modport sink (input valid, fire, output ready);
endinterface

// File: sv/cdt_datapath.sv
module cdt_datapath #(
	parameter int QUEUE_DEPTH = cdt_pkg::QUEUE_DEPTH_DEF,
	parameter int COUNT_BITS  = cdt_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cdt_pkg::cmd_t               cmd,
	output cdt_pkg::sts_t               sts,
	input  logic [cdt_pkg::LANE_W-1:0]  box_type,
	input  logic [cdt_pkg::LANE_W-1:0]  tick_lane,
	output logic                        fire
);

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH  = cdt_pkg::LANES * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [COUNT_BITS-1:0] gap_q  [cdt_pkg::LANES];
	logic [PTR_W-1:0]      head_q [cdt_pkg::LANES];
	logic [PTR_W-1:0]      tail_q [cdt_pkg::LANES];
	logic [FILL_W-1:0]     fill_q [cdt_pkg::LANES];

	logic [COUNT_BITS-1:0] mem [DEPTH];

	logic [COUNT_BITS-1:0]     rd_data_s1;
	logic [ADDR_W-1:0]         rd_addr_s1;
	logic [cdt_pkg::LANE_W-1:0] lane_s1;
	logic                      fire_q;

	logic              enq;
	logic              head_zero;
	logic              pop;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [COUNT_BITS-1:0] mem_wd;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	// enqueue and tick decode
	assign enq = cmd.box && (box_type != cdt_pkg::BOX_EMPTY) &&
		(fill_q[box_type] != FILL_W'(QUEUE_DEPTH));
	assign sts.tick_hit = (tick_lane != cdt_pkg::LANE_NONE) &&
		(fill_q[tick_lane] != '0);
	assign head_zero = (rd_data_s1 == '0);
	assign pop = cmd.tick_eval && head_zero;

	// entry addresses: lane base plus slot
	assign wr_addr = ADDR_W'(box_type) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_q[box_type]);
	assign rd_addr = ADDR_W'(tick_lane) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[tick_lane]);

	// single write port shared by enqueue and head decrement
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wr_addr;
		mem_wd = gap_q[box_type];
		if (enq) begin
			mem_we = 1'b1;
		end else if (cmd.tick_eval && !head_zero) begin
			mem_we = 1'b1;
			mem_wa = rd_addr_s1;
			mem_wd = rd_data_s1 - COUNT_BITS'(1);
		end
	end

	// entry memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.tick_rd) begin
			rd_data_s1 <= mem[rd_addr];
			rd_addr_s1 <= rd_addr;
			lane_s1    <= tick_lane;
		end
	end

	// gap counters and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cdt_pkg::LANES; i++) begin
				gap_q[i]  <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < cdt_pkg::LANES; i++) begin
				if (cmd.box) begin
					if (box_type == cdt_pkg::LANE_W'(i)) begin
						gap_q[i] <= '0;
					end else begin
						gap_q[i] <= gap_q[i] + COUNT_BITS'(1);
					end
				end
				if (enq && (box_type == cdt_pkg::LANE_W'(i))) begin
					tail_q[i] <= next_ptr(tail_q[i]);
					fill_q[i] <= fill_q[i] + FILL_W'(1);
				end
				if (pop && (lane_s1 == cdt_pkg::LANE_W'(i))) begin
					head_q[i] <= next_ptr(head_q[i]);
					fill_q[i] <= fill_q[i] - FILL_W'(1);
				end
			end
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			fire_q <= pop;
		end
	end

	assign fire = fire_q;

endmodule

// File: sv/cdt_ctrl.sv
module cdt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          evt_valid,
	input  logic          evt_kind,
	output logic          evt_ready,
	output logic          res_valid,
	input  logic          res_ready,
	input  cdt_pkg::sts_t sts,
	output cdt_pkg::cmd_t cmd
);

	cdt_pkg::state_t state_q;
	cdt_pkg::state_t state_nxt;
	logic            res_valid_q;

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cdt_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		evt_ready = 1'b0;
		unique case (state_q)
			cdt_pkg::ST_IDLE: begin
				evt_ready = !res_valid_q || res_ready;
				if (evt_valid && evt_ready) begin
					if (evt_kind == cdt_pkg::KIND_BOX) begin
						cmd.box      = 1'b1;
						cmd.load_res = 1'b1;
					end else if (sts.tick_hit) begin
						cmd.tick_rd = 1'b1;
						state_nxt   = cdt_pkg::ST_EVAL;
					end else begin
						cmd.load_res = 1'b1;
					end
				end
			end
			cdt_pkg::ST_EVAL: begin
				cmd.tick_eval = 1'b1;
				cmd.load_res  = 1'b1;
				state_nxt     = cdt_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = cdt_pkg::ST_IDLE;
			end
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

// File: sv/conveyor_divert_tracker.sv
// channel | dir | payload                     | handshake
// evt     | in  | kind, box_type, tick_lane   | valid / ready
// res     | out | fire                        | valid / ready
//
// box events and ticks on an empty or missing lane are done in the idle state
// ticks on a lane with entries use the idle then eval states: entry memory read, then pop or write back
// the result appears in the output register the cycle after the work ends
// a new transaction is taken only when no result waits or the waiting one leaves that cycle
// arst_n clears gap counters, queue pointers and fill counts; entries need no clearing
module conveyor_divert_tracker #(
	parameter int QUEUE_DEPTH = cdt_pkg::QUEUE_DEPTH_DEF,
	parameter int COUNT_BITS  = cdt_pkg::COUNT_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	cdt_evt_if.sink      evt,
	cdt_res_if.source    res
);

	cdt_pkg::cmd_t cmd;
	cdt_pkg::sts_t sts;

	// sequencing
	cdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_kind  (evt.kind),
		.evt_ready (evt.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// counters, queues and result payload
	cdt_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.box_type  (evt.box_type),
		.tick_lane (evt.tick_lane),
		.fire      (res.fire)
	);

endmodule

// File: sv/cdt_checker.sv
module cdt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       evt_valid,
	input logic                       evt_ready,
	input logic                       evt_kind,
	input logic [cdt_pkg::LANE_W-1:0] evt_tick_lane,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic                       res_fire
);

	// no result while in reset
	assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_fire))
		else $error("stalled result changed");

	// box transaction yields a non-firing result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && (evt_kind == cdt_pkg::KIND_BOX)
		|=> res_valid && !res_fire)
		else $error("box transaction result wrong");

	// tick on the missing lane yields a non-firing result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && (evt_kind == cdt_pkg::KIND_TICK) &&
		(evt_tick_lane == cdt_pkg::LANE_NONE)
		|=> res_valid && !res_fire)
		else $error("tick on missing lane result wrong");

	// no new transaction while a result is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !evt_ready)
		else $error("input taken while result stalled");

endmodule

bind conveyor_divert_tracker cdt_checker u_cdt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.evt_valid     (evt.valid),
	.evt_ready     (evt.ready),
	.evt_kind      (evt.kind),
	.evt_tick_lane (evt.tick_lane),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_fire      (res.fire)
);

// File: sim/conveyor_divert_tracker_tb.sv
module conveyor_divert_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LANE_W      = cdt_pkg::LANE_W;
	localparam int LANES       = cdt_pkg::LANES;
	localparam int QDEPTH      = cdt_pkg::QUEUE_DEPTH_DEF;
	localparam int CBITS       = cdt_pkg::COUNT_BITS_DEF;
	localparam int PTR_W       = $clog2(QDEPTH);
	localparam int FILL_W      = $clog2(QDEPTH + 1);
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 10;

	// box types and lane numbers
	localparam logic [LANE_W-1:0] BOX_S      = 2'd0;
	localparam logic [LANE_W-1:0] BOX_M      = 2'd1;
	localparam logic [LANE_W-1:0] BOX_L      = 2'd2;
	localparam logic [LANE_W-1:0] LANE_0     = 2'd0;
	localparam logic [LANE_W-1:0] LANE_1     = 2'd1;
	localparam logic [LANE_W-1:0] LANE_2     = 2'd2;

	typedef struct packed {
		logic              kind;
		logic [LANE_W-1:0] box_type;
		logic [LANE_W-1:0] tick_lane;
	} evt_item_t;

	logic clk;
	logic arst_n;

	cdt_evt_if evt_ch ();
	cdt_res_if res_ch ();

	conveyor_divert_tracker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch)
	);

	// tracker shadow state
	logic [CBITS-1:0]  gap_cnt   [LANES];
	logic [CBITS-1:0]  slot_val  [LANES][QDEPTH];
	logic [PTR_W-1:0]  rd_ptr    [LANES];
	logic [PTR_W-1:0]  wr_ptr    [LANES];
	logic [FILL_W-1:0] occupancy [LANES];

	evt_item_t evt_backlog[$];
	logic      pending_fire[$];

	int   send_idle_pct;
	int   recv_idle_pct;
	int   err_count;
	int   cycle_cnt;
	int   stim_count;
	logic evt_taken;

	function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
		return (int'(p) == QDEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	// applies one transaction to the shadow state and returns the pusher fire bit
	function automatic logic divert_fire(evt_item_t it);
		int   ln;
		logic fired;
		fired = 1'b0;
		if (it.kind == cdt_pkg::KIND_BOX) begin
			ln = int'(it.box_type);
			// enqueue the lane gap unless the slot is empty or the queue is full
			if (it.box_type != cdt_pkg::BOX_EMPTY && int'(occupancy[ln]) < QDEPTH) begin
				slot_val[ln][wr_ptr[ln]] = gap_cnt[ln];
				wr_ptr[ln] = ptr_next(wr_ptr[ln]);
				occupancy[ln] = occupancy[ln] + 1'b1;
			end
			for (int i = 0; i < LANES; i++) begin
				if (i == ln)
					gap_cnt[i] = '0;
				else
					gap_cnt[i] = gap_cnt[i] + 1'b1;
			end
		end else if (it.tick_lane != cdt_pkg::LANE_NONE) begin
			ln = int'(it.tick_lane);
			if (occupancy[ln] != '0) begin
				// zero head pops and fires, otherwise count it down
				if (slot_val[ln][rd_ptr[ln]] == '0) begin
					fired = 1'b1;
					rd_ptr[ln] = ptr_next(rd_ptr[ln]);
					occupancy[ln] = occupancy[ln] - 1'b1;
				end else begin
					slot_val[ln][rd_ptr[ln]] = slot_val[ln][rd_ptr[ln]] - 1'b1;
				end
			end
		end
		return fired;
	endfunction

	// clock and reset
	initial begin
		clk = 1'b0;
		arst_n = 1'b1;
		evt_ch.valid = 1'b0;
		evt_ch.kind = cdt_pkg::KIND_BOX;
		evt_ch.box_type = cdt_pkg::BOX_EMPTY;
		evt_ch.tick_lane = cdt_pkg::LANE_NONE;
		res_ch.ready = 1'b0;
		fork
			forever #5 clk = ~clk;
			begin
				#1 arst_n = 1'b0;
				repeat (3) @(negedge clk);
				arst_n = 1'b1;
			end
		join_none
	end

	// event driver
	always @(negedge clk) begin
		if (!arst_n) begin
			evt_ch.valid <= 1'b0;
			res_ch.ready <= 1'b0;
		end else begin
			if (!evt_ch.valid || evt_taken) begin
				if (evt_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					evt_item_t nx;
					nx = evt_backlog.pop_front();
					evt_ch.valid     <= 1'b1;
					evt_ch.kind      <= nx.kind;
					evt_ch.box_type  <= nx.box_type;
					evt_ch.tick_lane <= nx.tick_lane;
				end else begin
					evt_ch.valid <= 1'b0;
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (!arst_n) begin
			evt_taken <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				gap_cnt[i]   = '0;
				rd_ptr[i]    = '0;
				wr_ptr[i]    = '0;
				occupancy[i] = '0;
			end
		end else begin
			evt_taken <= evt_ch.valid && evt_ch.ready;
			// result transaction against the oldest expectation
			if (res_ch.valid && res_ch.ready) begin
				if (pending_fire.size() == 0) begin
					$display("%0t: unexpected fire result, expected none actual %0b",
						$time, res_ch.fire);
					err_count++;
				end else begin
					logic want;
					want = pending_fire.pop_front();
					if (res_ch.fire !== want) begin
						$display("%0t: fire mismatch, expected %0b actual %0b",
							$time, want, res_ch.fire);
						err_count++;
					end
				end
			end
			// event transaction into the predictor
			if (evt_ch.valid && evt_ch.ready) begin
				evt_item_t got;
				got.kind      = evt_ch.kind;
				got.box_type  = evt_ch.box_type;
				got.tick_lane = evt_ch.tick_lane;
				pending_fire.push_back(divert_fire(got));
			end
		end
	end

	task automatic add_item(logic k, logic [LANE_W-1:0] b, logic [LANE_W-1:0] t);
		evt_item_t it;
		it.kind = k;
		it.box_type = b;
		it.tick_lane = t;
		evt_backlog.push_back(it);
		if (!(k == cdt_pkg::KIND_TICK && t == cdt_pkg::LANE_NONE))
			stim_count++;
	endtask

	// bursts of boxes and ticks with some noise mixed in
	task automatic random_phase(int target);
		int               n;
		int               pick;
		logic [LANE_W-1:0] ln;
		stim_count = 0;
		while (stim_count < target) begin
			pick = $urandom_range(9);
			if (pick < 2) begin
				add_item(1'($urandom_range(1)), 2'($urandom_range(3)), 2'($urandom_range(3)));
			end else if (pick < 5) begin
				// mixed box types
				n = $urandom_range(1, 6);
				repeat (n) begin
					if ($urandom_range(4) == 0)
						add_item(cdt_pkg::KIND_BOX, cdt_pkg::BOX_EMPTY,
							2'($urandom_range(3)));
					else
						add_item(cdt_pkg::KIND_BOX, 2'($urandom_range(2)),
							2'($urandom_range(3)));
				end
			end else if (pick == 5) begin
				// same box type, may fill the queue
				ln = 2'($urandom_range(2));
				n = $urandom_range(1, 10);
				repeat (n) add_item(cdt_pkg::KIND_BOX, ln, 2'($urandom_range(3)));
			end else begin
				// ticks on one lane until it likely drains
				ln = 2'($urandom_range(2));
				n = $urandom_range(1, 10);
				repeat (n) add_item(cdt_pkg::KIND_TICK, 2'($urandom_range(3)), ln);
			end
		end
	endtask

	task automatic wait_backlog_done();
		while (evt_backlog.size() != 0 || evt_ch.valid) @(posedge clk);
		while (pending_fire.size() != 0) @(posedge clk);
	endtask

	// stimulus sequence
	initial begin
		logic [LANE_W-1:0] wrap_lane;
		err_count = 0;
		cycle_cnt = 0;
		stim_count = 0;
		send_idle_pct = 9;
		recv_idle_pct = 51;
		@(posedge arst_n);
		@(posedge clk);

		// empty and missing lanes
		add_item(cdt_pkg::KIND_TICK, cdt_pkg::BOX_EMPTY, LANE_0);
		add_item(cdt_pkg::KIND_TICK, BOX_S, cdt_pkg::LANE_NONE);
		add_item(cdt_pkg::KIND_TICK, cdt_pkg::BOX_EMPTY, cdt_pkg::LANE_NONE);
		// zero gap pops at once
		add_item(cdt_pkg::KIND_BOX, BOX_S, cdt_pkg::LANE_NONE);
		add_item(cdt_pkg::KIND_TICK, cdt_pkg::BOX_EMPTY, LANE_0);
		add_item(cdt_pkg::KIND_BOX, cdt_pkg::BOX_EMPTY, LANE_2);
		// nonzero gap counts down then fires
		add_item(cdt_pkg::KIND_BOX, BOX_M, LANE_0);
		add_item(cdt_pkg::KIND_TICK, BOX_L, LANE_1);
		add_item(cdt_pkg::KIND_TICK, cdt_pkg::BOX_EMPTY, LANE_1);
		add_item(cdt_pkg::KIND_TICK, BOX_S, LANE_1);
		add_item(cdt_pkg::KIND_TICK, cdt_pkg::BOX_EMPTY, LANE_1);
		add_item(cdt_pkg::KIND_BOX, BOX_L, LANE_2);
		// overfill lane 0 so the last box is dropped
		repeat (9) add_item(cdt_pkg::KIND_BOX, BOX_S, LANE_1);
		add_item(cdt_pkg::KIND_TICK, cdt_pkg::BOX_EMPTY, LANE_2);
		add_item(cdt_pkg::KIND_TICK, cdt_pkg::BOX_EMPTY, LANE_2);
		add_item(cdt_pkg::KIND_TICK, cdt_pkg::BOX_EMPTY, LANE_0);
		add_item(cdt_pkg::KIND_TICK, BOX_M, LANE_0);

		random_phase(130);
		wait_backlog_done();

		send_idle_pct = 51;
		recv_idle_pct = 9;
		random_phase(130);
		wait_backlog_done();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(100);
		// long run of empty slots wraps the gap counters
		repeat ($urandom_range(250, 262))
			add_item(cdt_pkg::KIND_BOX, cdt_pkg::BOX_EMPTY, 2'($urandom_range(3)));
		wrap_lane = 2'($urandom_range(2));
		add_item(cdt_pkg::KIND_BOX, wrap_lane, cdt_pkg::LANE_NONE);
		repeat (30) add_item(cdt_pkg::KIND_TICK, 2'($urandom_range(3)), wrap_lane);
		wait_backlog_done();

		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_fire.size() != 0) begin
			$display("%0t: %0d fire results never arrived", $time, pending_fire.size());
			err_count++;
		end
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: conveyor_divert_tracker.f
sv/cdt_pkg.sv
sv/cdt_if.sv
sv/cdt_datapath.sv
sv/cdt_ctrl.sv
sv/conveyor_divert_tracker.sv
sv/cdt_checker.sv
sim/conveyor_divert_tracker_tb.sv
